// ===== rtl/kml_pkg.sv =====
// ----------------------------------------------------------------------------
// kml_pkg
// Shared types and codes of the k-means engine: operation codes, register
// indexes and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package kml_pkg;

    localparam int COORD_W = 16;
    localparam int OP_W    = 3;
    localparam int ROW_W   = 10;
    localparam int DIMI_W  = 4;
    localparam int CFGI_W  = 2;
    localparam int CFGD_W  = 11;
    localparam int ITER_W  = 8;

    localparam logic [OP_W-1:0] OP_LOAD_POINT = 3'd0;
    localparam logic [OP_W-1:0] OP_LOAD_CENT  = 3'd1;
    localparam logic [OP_W-1:0] OP_RUN        = 3'd2;
    localparam logic [OP_W-1:0] OP_READ_LABEL = 3'd3;
    localparam logic [OP_W-1:0] OP_READ_CENT  = 3'd4;

    localparam logic [CFGI_W-1:0] CFG_NUM_POINTS   = 2'd0;
    localparam logic [CFGI_W-1:0] CFG_NUM_CLUSTERS = 2'd1;
    localparam logic [CFGI_W-1:0] CFG_NUM_DIMS     = 2'd2;
    localparam logic [CFGI_W-1:0] CFG_NUM_ITERS    = 2'd3;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_CLR_LABEL,
        DP_CLR_SUM,
        DP_DIST,
        DP_LABEL,
        DP_SUM_RD,
        DP_SUM_WR,
        DP_UPD_RD,
        DP_DIV,
        DP_UPD_WR,
        DP_HOST,
        DP_RUN_DONE
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   first;
        logic   last;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
        logic cnt_zero;
    } t_dp_stat;

endpackage

// ===== rtl/kml_div.sv =====
// ----------------------------------------------------------------------------
// kml_div
// Radix-2 restoring divider: signed sum by unsigned count, truncated toward
// zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kml_div #(
    parameter int SW  = 27,
    parameter int CNW = 11
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [SW-1:0] i_dividend,
    input  logic [CNW-1:0]       i_divisor,
    output logic                 o_done,
    output logic signed [15:0]   o_quotient
);
    localparam int CTW = $clog2(SW + 1);

    logic           r_busy;
    logic           r_done;
    logic [CTW-1:0] r_cnt;
    logic [CNW-1:0] r_rem;
    logic [CNW-1:0] r_den;
    logic [SW-1:0]  r_quo;
    logic           r_neg;
    logic [CNW:0]   rem_sh;
    logic           fits;

    assign rem_sh = {r_rem, r_quo[SW-1]};
    assign fits   = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CTW'(SW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[SW-1];
            r_quo <= i_dividend[SW-1] ? SW'(-i_dividend) : SW'(i_dividend);
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? CNW'(rem_sh - {1'b0, r_den}) : CNW'(rem_sh);
            r_quo <= {r_quo[SW-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? signed'(16'(~r_quo[15:0] + 16'd1)) : signed'(r_quo[15:0]);

endmodule

// ===== rtl/kml_dp.sv =====
// ----------------------------------------------------------------------------
// kml_dp
// Datapath of the k-means engine: point, centroid, label and sum memories,
// the distance pipeline, the cluster counts and the divider.
// ----------------------------------------------------------------------------
module kml_dp #(
    parameter int MAX_POINTS   = 1024,
    parameter int MAX_CLUSTERS = 16,
    parameter int MAX_DIMS     = 16,
    localparam int PIW = $clog2(MAX_POINTS),
    localparam int CIW = $clog2(MAX_CLUSTERS),
    localparam int DIW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1,
    localparam int PCW = $clog2(MAX_POINTS + 1),
    localparam int CCW = $clog2(MAX_CLUSTERS + 1),
    localparam int DCW = $clog2(MAX_DIMS + 1),
    localparam int CAW = $clog2(MAX_CLUSTERS * MAX_DIMS)
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  kml_pkg::t_dp_cmd                 i_cmd,
    output kml_pkg::t_dp_stat                o_stat,
    input  logic [PIW-1:0]                   i_pt,
    input  logic [CIW-1:0]                   i_cl,
    input  logic [DIW-1:0]                   i_dim,
    input  logic [CAW-1:0]                   i_sweep,
    input  logic [PCW-1:0]                   i_np,
    input  logic [CCW-1:0]                   i_nc,
    input  logic [DCW-1:0]                   i_nd,
    input  logic [kml_pkg::OP_W-1:0]         i_op,
    input  logic [kml_pkg::ROW_W-1:0]        i_row,
    input  logic [kml_pkg::DIMI_W-1:0]       i_dim_index,
    input  logic signed [kml_pkg::COORD_W-1:0] i_coord,
    output logic                             o_valid,
    output logic signed [kml_pkg::COORD_W-1:0] o_read_value,
    output logic                             o_status
);
    import kml_pkg::*;

    localparam int PAW = $clog2(MAX_POINTS * MAX_DIMS);
    localparam int SW  = 17 + $clog2(MAX_POINTS);
    localparam int DSW = 32 + $clog2(MAX_DIMS);

    typedef enum logic [1:0] {SEL_ZERO, SEL_LABEL, SEL_CENT} t_sel;

    logic signed [COORD_W-1:0] r_pt_mem [MAX_POINTS*MAX_DIMS];
    logic signed [COORD_W-1:0] r_ct_mem [MAX_CLUSTERS*MAX_DIMS];
    logic [CIW-1:0]            r_lb_mem [MAX_POINTS];
    logic signed [SW-1:0]      r_sum_mem [MAX_CLUSTERS*MAX_DIMS];
    logic [PCW-1:0]            r_cnt [MAX_CLUSTERS];

    logic signed [COORD_W-1:0] r_pt_q, r_ct_q;
    logic [CIW-1:0]            r_lb_q;
    logic signed [SW-1:0]      r_sum_q;

    logic           r_s1_v, r_s1_first, r_s1_last;
    logic [CIW-1:0] r_s1_cl;
    logic           r_s2_v, r_s2_first, r_s2_last;
    logic [CIW-1:0] r_s2_cl;
    logic [31:0]    r_sq;
    logic [DSW-1:0] r_acc, r_best, n_acc;
    logic [CIW-1:0] r_best_cl;

    logic           r_out_valid, r_out_status;
    t_sel           r_out_sel;

    logic is_host, pt_ok, cl_ok, dim_ok, host_err;
    logic pt_we, ct_we, lb_we, sum_we;
    logic [PAW-1:0] pt_addr;
    logic [CAW-1:0] ct_addr, sum_addr;
    logic [PIW-1:0] lb_addr;
    logic signed [COORD_W-1:0] ct_wdata;
    logic signed [SW-1:0]      sum_wdata;
    logic [CIW-1:0] cnt_idx;
    logic [PCW-1:0] cnt_rd;
    logic signed [16:0] diff;
    logic signed [15:0] div_q;
    logic           div_done;
    t_sel host_sel;

    assign is_host = i_cmd.op == DP_HOST;
    assign pt_ok   = i_row < i_np;
    assign cl_ok   = i_row < i_nc;
    assign dim_ok  = i_dim_index < i_nd;

    always_comb begin
        host_err = 1'b0;
        host_sel = SEL_ZERO;
        unique case (i_op)
            OP_LOAD_POINT: host_err = !(pt_ok && dim_ok);
            OP_LOAD_CENT:  host_err = !(cl_ok && dim_ok);
            OP_RUN:        host_err = 1'b0;
            OP_READ_LABEL: begin
                host_err = !pt_ok;
                host_sel = pt_ok ? SEL_LABEL : SEL_ZERO;
            end
            OP_READ_CENT: begin
                host_err = !(cl_ok && dim_ok);
                host_sel = (cl_ok && dim_ok) ? SEL_CENT : SEL_ZERO;
            end
            default:       host_err = 1'b1;
        endcase
    end

    // Address steering: the host owns the memories only while the engine idles.
    assign pt_addr = is_host ? PAW'(PIW'(i_row) * MAX_DIMS) + PAW'(DIW'(i_dim_index))
                             : PAW'(i_pt * MAX_DIMS) + PAW'(i_dim);
    assign ct_addr = is_host ? CAW'(CIW'(i_row) * MAX_DIMS) + CAW'(DIW'(i_dim_index))
                             : CAW'(i_cl * MAX_DIMS) + CAW'(i_dim);
    assign lb_addr = is_host ? PIW'(i_row) : i_pt;

    always_comb begin
        if (i_cmd.op == DP_CLR_SUM) begin
            sum_addr = i_sweep;
        end else if (i_cmd.op == DP_UPD_RD) begin
            sum_addr = CAW'(i_cl * MAX_DIMS) + CAW'(i_dim);
        end else begin
            sum_addr = CAW'(r_best_cl * MAX_DIMS) + CAW'(i_dim);
        end
    end

    assign pt_we     = is_host && i_op == OP_LOAD_POINT && pt_ok && dim_ok;
    assign ct_we     = (is_host && i_op == OP_LOAD_CENT && cl_ok && dim_ok)
                       || i_cmd.op == DP_UPD_WR;
    assign ct_wdata  = is_host ? i_coord : div_q;
    assign lb_we     = i_cmd.op == DP_CLR_LABEL || i_cmd.op == DP_LABEL;
    assign sum_we    = i_cmd.op == DP_CLR_SUM || i_cmd.op == DP_SUM_WR;
    assign sum_wdata = (i_cmd.op == DP_CLR_SUM) ? '0 : r_sum_q + SW'(r_pt_q);

    always_ff @(posedge i_clk) begin
        if (pt_we) begin
            r_pt_mem[pt_addr] <= i_coord;
        end
        r_pt_q <= r_pt_mem[pt_addr];
    end

    always_ff @(posedge i_clk) begin
        if (ct_we) begin
            r_ct_mem[ct_addr] <= ct_wdata;
        end
        r_ct_q <= r_ct_mem[ct_addr];
    end

    always_ff @(posedge i_clk) begin
        if (lb_we) begin
            r_lb_mem[lb_addr] <= (i_cmd.op == DP_CLR_LABEL) ? '0 : r_best_cl;
        end
        r_lb_q <= r_lb_mem[lb_addr];
    end

    always_ff @(posedge i_clk) begin
        if (sum_we) begin
            r_sum_mem[sum_addr] <= sum_wdata;
        end
        r_sum_q <= r_sum_mem[sum_addr];
    end

    // Per-cluster counts, cleared during the sum sweep of every round.
    assign cnt_idx = (i_cmd.op == DP_LABEL) ? r_best_cl : i_cl;
    assign cnt_rd  = r_cnt[cnt_idx];

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == DP_CLR_SUM) begin
            for (int c = 0; c < MAX_CLUSTERS; c++) begin
                r_cnt[c] <= '0;
            end
        end else if (i_cmd.op == DP_LABEL) begin
            r_cnt[cnt_idx] <= cnt_rd + 1'b1;
        end
    end

    // Distance pipeline: read, square, accumulate and compare.
    assign diff = 17'(r_pt_q) - 17'(r_ct_q);

    always_comb begin
        n_acc = r_s2_first ? DSW'(r_sq) : r_acc + DSW'(r_sq);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_s1_v <= i_cmd.op == DP_DIST;
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_first <= i_cmd.first;
        r_s1_last  <= i_cmd.last;
        r_s1_cl    <= i_cl;
        r_s2_first <= r_s1_first;
        r_s2_last  <= r_s1_last;
        r_s2_cl    <= r_s1_cl;
        r_sq       <= 32'(diff * diff);
        if (r_s2_v) begin
            r_acc <= n_acc;
            if (r_s2_last && (r_s2_cl == '0 || n_acc < r_best)) begin
                r_best    <= n_acc;
                r_best_cl <= r_s2_cl;
            end
        end
    end

    kml_div #(
        .SW  (SW),
        .CNW (PCW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.op == DP_DIV),
        .i_dividend (r_sum_q),
        .i_divisor  (cnt_rd),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign o_stat = '{div_done: div_done, cnt_zero: cnt_rd == '0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= is_host || i_cmd.op == DP_RUN_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_status <= is_host && host_err;
        r_out_sel    <= is_host ? host_sel : SEL_ZERO;
    end

    always_comb begin
        unique case (r_out_sel)
            SEL_LABEL: o_read_value = signed'(16'(r_lb_q));
            SEL_CENT:  o_read_value = r_ct_q;
            default:   o_read_value = '0;
        endcase
    end

    assign o_valid  = r_out_valid;
    assign o_status = r_out_status;

endmodule

// ===== rtl/kml_ctrl.sv =====
// ----------------------------------------------------------------------------
// kml_ctrl
// Sequencer of the k-means engine: label clearing after reset, host access,
// and the loops over rounds, points, clusters and dimensions.
// ----------------------------------------------------------------------------
module kml_ctrl #(
    parameter int MAX_POINTS   = 1024,
    parameter int MAX_CLUSTERS = 16,
    parameter int MAX_DIMS     = 16,
    localparam int PIW = $clog2(MAX_POINTS),
    localparam int CIW = $clog2(MAX_CLUSTERS),
    localparam int DIW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1,
    localparam int PCW = $clog2(MAX_POINTS + 1),
    localparam int CCW = $clog2(MAX_CLUSTERS + 1),
    localparam int DCW = $clog2(MAX_DIMS + 1),
    localparam int CAW = $clog2(MAX_CLUSTERS * MAX_DIMS)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [kml_pkg::OP_W-1:0]    i_op,
    output logic                        o_busy,
    input  logic [kml_pkg::ITER_W-1:0]  i_num_iter,
    input  logic [PCW-1:0]              i_np,
    input  logic [CCW-1:0]              i_nc,
    input  logic [DCW-1:0]              i_nd,
    input  kml_pkg::t_dp_stat           i_stat,
    output kml_pkg::t_dp_cmd            o_cmd,
    output logic [PIW-1:0]              o_pt,
    output logic [CIW-1:0]              o_cl,
    output logic [DIW-1:0]              o_dim,
    output logic [CAW-1:0]              o_sweep
);
    import kml_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_CLRSUM, ST_DIST, ST_DRAIN, ST_LABEL, ST_SUM_RD,
        ST_SUM_WR, ST_UPD_CHK, ST_UPD_RD, ST_DIV_GO, ST_DIV_WAIT, ST_UPD_WR,
        ST_ROUND_END, ST_DONE
    } t_state;

    t_state              r_state;
    logic [PIW-1:0]      r_pt;
    logic [CIW-1:0]      r_cl;
    logic [DIW-1:0]      r_dim;
    logic [CAW-1:0]      r_sweep;
    logic [ITER_W-1:0]   r_it;
    logic                r_drain;
    logic                last_pt, last_cl, last_dim;

    assign last_pt  = PCW'(r_pt) + 1'b1 == i_np;
    assign last_cl  = CCW'(r_cl) + 1'b1 == i_nc;
    assign last_dim = DCW'(r_dim) + 1'b1 == i_nd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_pt    <= '0;
            r_cl    <= '0;
            r_dim   <= '0;
            r_sweep <= '0;
            r_it    <= '0;
            r_drain <= 1'b0;
        end else begin
            unique case (r_state)
                ST_CLEAR: begin
                    r_pt <= r_pt + 1'b1;
                    if (r_pt == PIW'(MAX_POINTS - 1)) begin
                        r_pt    <= '0;
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_start && i_op == OP_RUN) begin
                        r_it    <= i_num_iter;
                        r_sweep <= '0;
                        r_state <= (i_num_iter == '0) ? ST_DONE : ST_CLRSUM;
                    end
                end
                ST_CLRSUM: begin
                    r_sweep <= r_sweep + 1'b1;
                    if (r_sweep == CAW'(MAX_CLUSTERS * MAX_DIMS - 1)) begin
                        r_pt    <= '0;
                        r_cl    <= '0;
                        r_dim   <= '0;
                        r_state <= ST_DIST;
                    end
                end
                ST_DIST: begin
                    if (last_dim) begin
                        r_dim <= '0;
                        if (last_cl) begin
                            r_cl    <= '0;
                            r_drain <= 1'b0;
                            r_state <= ST_DRAIN;
                        end else begin
                            r_cl <= r_cl + 1'b1;
                        end
                    end else begin
                        r_dim <= r_dim + 1'b1;
                    end
                end
                ST_DRAIN: begin
                    r_drain <= 1'b1;
                    if (r_drain) begin
                        r_state <= ST_LABEL;
                    end
                end
                ST_LABEL: begin
                    r_dim   <= '0;
                    r_state <= ST_SUM_RD;
                end
                ST_SUM_RD: r_state <= ST_SUM_WR;
                ST_SUM_WR: begin
                    if (last_dim) begin
                        r_dim <= '0;
                        if (last_pt) begin
                            r_pt    <= '0;
                            r_cl    <= '0;
                            r_state <= ST_UPD_CHK;
                        end else begin
                            r_pt    <= r_pt + 1'b1;
                            r_state <= ST_DIST;
                        end
                    end else begin
                        r_dim   <= r_dim + 1'b1;
                        r_state <= ST_SUM_RD;
                    end
                end
                ST_UPD_CHK: begin
                    r_dim <= '0;
                    if (!i_stat.cnt_zero) begin
                        r_state <= ST_UPD_RD;
                    end else if (last_cl) begin
                        r_state <= ST_ROUND_END;
                    end else begin
                        r_cl <= r_cl + 1'b1;
                    end
                end
                ST_UPD_RD: r_state <= ST_DIV_GO;
                ST_DIV_GO: r_state <= ST_DIV_WAIT;
                ST_DIV_WAIT: begin
                    if (i_stat.div_done) begin
                        r_state <= ST_UPD_WR;
                    end
                end
                ST_UPD_WR: begin
                    if (last_dim) begin
                        if (last_cl) begin
                            r_state <= ST_ROUND_END;
                        end else begin
                            r_cl    <= r_cl + 1'b1;
                            r_state <= ST_UPD_CHK;
                        end
                    end else begin
                        r_dim   <= r_dim + 1'b1;
                        r_state <= ST_UPD_RD;
                    end
                end
                ST_ROUND_END: begin
                    r_it    <= r_it - 1'b1;
                    r_cl    <= '0;
                    r_sweep <= '0;
                    r_state <= (r_it == ITER_W'(1)) ? ST_DONE : ST_CLRSUM;
                end
                ST_DONE: r_state <= ST_IDLE;
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd.first = r_dim == '0;
        o_cmd.last  = last_dim;
        unique case (r_state)
            ST_CLEAR:  o_cmd.op = DP_CLR_LABEL;
            ST_IDLE:   o_cmd.op = (i_start && i_op != OP_RUN) ? DP_HOST : DP_NOP;
            ST_CLRSUM: o_cmd.op = DP_CLR_SUM;
            ST_DIST:   o_cmd.op = DP_DIST;
            ST_LABEL:  o_cmd.op = DP_LABEL;
            ST_SUM_RD: o_cmd.op = DP_SUM_RD;
            ST_SUM_WR: o_cmd.op = DP_SUM_WR;
            ST_UPD_RD: o_cmd.op = DP_UPD_RD;
            ST_DIV_GO: o_cmd.op = DP_DIV;
            ST_UPD_WR: o_cmd.op = DP_UPD_WR;
            ST_DONE:   o_cmd.op = DP_RUN_DONE;
            default:   o_cmd.op = DP_NOP;
        endcase
    end

    assign o_busy  = r_state != ST_IDLE;
    assign o_pt    = r_pt;
    assign o_cl    = r_cl;
    assign o_dim   = r_dim;
    assign o_sweep = r_sweep;

    a_host_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_start && i_op != OP_RUN) |=> r_state == ST_IDLE)
        else $error("host access left the idle state");

    a_dist_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIST |-> (CCW'(r_cl) < i_nc && DCW'(r_dim) < i_nd))
        else $error("distance walk outside the configured sizes");

    a_sum_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SUM_WR |-> $past(r_state) == ST_SUM_RD)
        else $error("sum write without its read");

    a_update_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD_CHK && !i_stat.cnt_zero) |=> r_state == ST_UPD_RD)
        else $error("non-empty cluster skipped in update");

endmodule

// ===== rtl/kmeans_lloyd_iterations_top.sv =====
// ----------------------------------------------------------------------------
// kmeans_lloyd_iterations_top
// K-means (Lloyd) engine over signed Q8.8 coordinates with host load, run
// and read-back operations.
// ----------------------------------------------------------------------------
// Usage. A command word is taken at a rising edge where start is high and
// busy is low. Point and centroid coordinates are loaded one per word, a run
// word performs the configured number of rounds, and labels and centroid
// coordinates are read back one per word. Every word yields exactly one
// result, shown for one cycle with o_valid high; the receiver cannot stall,
// so the result must be taken in that cycle.
// Loads and reads answer in the cycle after acceptance and a new word may be
// accepted every cycle. A run keeps busy high until its result; each round
// clears the sums, then for each point walks the configured clusters and
// dimensions for the distances, labels the point and adds it into its
// cluster's sums, then per cluster checks the count and, for a non-empty
// cluster, divides each sum by it; sums are SW bits wide (27 by default).
// Size registers are written on the config channel, which is always ready,
// and must only be written while the engine is idle.
// After reset the label memory is cleared one entry per cycle, with busy high;
// config writes are taken meanwhile.
// ----------------------------------------------------------------------------
module kmeans_lloyd_iterations_top #(
    parameter int MAX_POINTS   = 1024,
    parameter int MAX_CLUSTERS = 16,
    parameter int MAX_DIMS     = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [kml_pkg::OP_W-1:0]           i_op,
    input  logic [kml_pkg::ROW_W-1:0]          i_row_index,
    input  logic [kml_pkg::DIMI_W-1:0]         i_dim_index,
    input  logic signed [kml_pkg::COORD_W-1:0] i_coord_value,
    output logic                               o_valid,
    output logic signed [kml_pkg::COORD_W-1:0] o_read_value,
    output logic                               o_status,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [kml_pkg::CFGI_W-1:0]         i_cfg_index,
    input  logic [kml_pkg::CFGD_W-1:0]         i_cfg_data
);
    import kml_pkg::*;

    localparam int PIW = $clog2(MAX_POINTS);
    localparam int CIW = $clog2(MAX_CLUSTERS);
    localparam int DIW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int PCW = $clog2(MAX_POINTS + 1);
    localparam int CCW = $clog2(MAX_CLUSTERS + 1);
    localparam int DCW = $clog2(MAX_DIMS + 1);
    localparam int CAW = $clog2(MAX_CLUSTERS * MAX_DIMS);

    // Configuration registers, at the widths of the register map.
    logic [10:0]       r_num_points;
    logic [4:0]        r_num_clusters;
    logic [4:0]        r_num_dims;
    logic [ITER_W-1:0] r_num_iters;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_points   <= 11'd1;
            r_num_clusters <= 5'd1;
            r_num_dims     <= 5'd1;
            r_num_iters    <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_NUM_POINTS:   r_num_points   <= i_cfg_data;
                CFG_NUM_CLUSTERS: r_num_clusters <= i_cfg_data[4:0];
                CFG_NUM_DIMS:     r_num_dims     <= i_cfg_data[4:0];
                CFG_NUM_ITERS:    r_num_iters    <= i_cfg_data[ITER_W-1:0];
                default:          r_num_iters    <= r_num_iters;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // Effective sizes: each register is clamped into one up to the maximum.
    logic [PCW-1:0] np;
    logic [CCW-1:0] nc;
    logic [DCW-1:0] nd;

    assign np = (r_num_points == '0) ? PCW'(1)
              : (r_num_points > MAX_POINTS) ? PCW'(MAX_POINTS) : PCW'(r_num_points);
    assign nc = (r_num_clusters == '0) ? CCW'(1)
              : (r_num_clusters > MAX_CLUSTERS) ? CCW'(MAX_CLUSTERS) : CCW'(r_num_clusters);
    assign nd = (r_num_dims == '0) ? DCW'(1)
              : (r_num_dims > MAX_DIMS) ? DCW'(MAX_DIMS) : DCW'(r_num_dims);

    t_dp_cmd        cmd;
    t_dp_stat       stat;
    logic [PIW-1:0] pt;
    logic [CIW-1:0] cl;
    logic [DIW-1:0] dim;
    logic [CAW-1:0] sweep;

    kml_ctrl #(
        .MAX_POINTS   (MAX_POINTS),
        .MAX_CLUSTERS (MAX_CLUSTERS),
        .MAX_DIMS     (MAX_DIMS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_op       (i_op),
        .o_busy     (busy),
        .i_num_iter (r_num_iters),
        .i_np       (np),
        .i_nc       (nc),
        .i_nd       (nd),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_pt       (pt),
        .o_cl       (cl),
        .o_dim      (dim),
        .o_sweep    (sweep)
    );

    kml_dp #(
        .MAX_POINTS   (MAX_POINTS),
        .MAX_CLUSTERS (MAX_CLUSTERS),
        .MAX_DIMS     (MAX_DIMS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_pt         (pt),
        .i_cl         (cl),
        .i_dim        (dim),
        .i_sweep      (sweep),
        .i_np         (np),
        .i_nc         (nc),
        .i_nd         (nd),
        .i_op         (i_op),
        .i_row        (i_row_index),
        .i_dim_index  (i_dim_index),
        .i_coord      (i_coord_value),
        .o_valid      (o_valid),
        .o_read_value (o_read_value),
        .o_status     (o_status)
    );

endmodule

// ===== sim/kmeans_lloyd_iterations_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmeans_lloyd_iterations_top_tb
// Self-checking bench for the k-means engine. A directed table covers the
// reset state, index errors, unused operations and coordinate extremes. It is
// followed by phases of random command words under several size settings.
// Results are checked against table answers or a cycle-free Lloyd model.
// ----------------------------------------------------------------------------
module kmeans_lloyd_iterations_top_tb;

    import kml_pkg::*;

    localparam int NPT = 1024;
    localparam int NCL = 16;
    localparam int NDM = 16;

    // Clock and the block's ports.
    logic                       i_clk;
    logic                       i_rst_n;
    logic                       start;
    logic                       busy;
    logic [OP_W-1:0]            i_op;
    logic [ROW_W-1:0]           i_row_index;
    logic [DIMI_W-1:0]          i_dim_index;
    logic signed [COORD_W-1:0]  i_coord_value;
    logic                       o_valid;
    logic signed [COORD_W-1:0]  o_read_value;
    logic                       o_status;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [CFGI_W-1:0]          i_cfg_index;
    logic [CFGD_W-1:0]          i_cfg_data;

    kmeans_lloyd_iterations_top i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_op         (i_op),
        .i_row_index  (i_row_index),
        .i_dim_index  (i_dim_index),
        .i_coord_value(i_coord_value),
        .o_valid      (o_valid),
        .o_read_value (o_read_value),
        .o_status     (o_status),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Expected answers, oldest first.
    typedef struct {
        logic signed [COORD_W-1:0] value;
        logic                      status;
    } t_answer;

    t_answer answer_q[$];
    int      errors;
    int      gap_pct;

    // Shadow copy of the engine state.
    logic signed [COORD_W-1:0] pt_mem   [NPT][NDM];
    logic signed [COORD_W-1:0] cent_mem [NCL][NDM];
    logic [3:0]                label_mem[NPT];
    bit                        pt_loaded  [NPT][NDM];
    bit                        cent_loaded[NCL][NDM];
    logic [10:0]               reg_points;
    logic [4:0]                reg_clusters;
    logic [4:0]                reg_dims;
    logic [7:0]                reg_iters;

    // Directed stimulus. Rows with has_exp carry an answer that is obvious.
    typedef struct {
        logic [OP_W-1:0]           op;
        int                        row;
        int                        dim;
        logic signed [COORD_W-1:0] coord;
        bit                        has_exp;
        logic signed [COORD_W-1:0] exp_value;
        logic                      exp_status;
    } t_row;

    localparam logic [OP_W-1:0] OP_SPARE5 = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

    t_row directed[] = '{
        '{OP_READ_LABEL, 0,    0,  16'sd0,      1, 16'sd0,      1'b0},
        '{OP_READ_LABEL, 1,    0,  16'sd0,      1, 16'sd0,      1'b1},
        '{OP_READ_LABEL, 1023, 15, 16'sd0,      1, 16'sd0,      1'b1},
        '{OP_SPARE5,     0,    0,  16'sd0,      1, 16'sd0,      1'b1},
        '{OP_SPARE6,     0,    0,  -16'sd1,     1, 16'sd0,      1'b1},
        '{OP_SPARE7,     1023, 15, 16'sd0,      1, 16'sd0,      1'b1},
        '{OP_LOAD_POINT, 0,    0,  16'sd32767,  1, 16'sd0,      1'b0},
        '{OP_LOAD_POINT, 1,    0,  16'sd5,      1, 16'sd0,      1'b1},
        '{OP_LOAD_POINT, 0,    1,  16'sd5,      1, 16'sd0,      1'b1},
        '{OP_LOAD_CENT,  0,    0,  -16'sd32768, 1, 16'sd0,      1'b0},
        '{OP_LOAD_CENT,  1,    0,  16'sd7,      1, 16'sd0,      1'b1},
        '{OP_LOAD_CENT,  0,    15, 16'sd7,      1, 16'sd0,      1'b1},
        '{OP_READ_CENT,  0,    0,  16'sd0,      1, -16'sd32768, 1'b0},
        '{OP_READ_CENT,  1023, 15, 16'sd0,      1, 16'sd0,      1'b1},
        '{OP_RUN,        0,    0,  16'sd0,      1, 16'sd0,      1'b0},
        '{OP_READ_CENT,  0,    0,  16'sd0,      1, -16'sd32768, 1'b0},
        '{OP_READ_LABEL, 0,    0,  16'sd0,      1, 16'sd0,      1'b0},
        '{OP_LOAD_CENT,  0,    0,  16'sd32767,  0, 16'sd0,      1'b0},
        '{OP_READ_CENT,  0,    0,  16'sd0,      0, 16'sd0,      1'b0}
    };

    function automatic int clamp_size(int v, int max_v);
        if (v < 1) return 1;
        if (v > max_v) return max_v;
        return v;
    endfunction

    function automatic int eff_points();
        return clamp_size(reg_points, NPT);
    endfunction

    function automatic int eff_clusters();
        return clamp_size(reg_clusters, NCL);
    endfunction

    function automatic int eff_dims();
        return clamp_size(reg_dims, NDM);
    endfunction

    // A run with rounds may only touch coordinates that were loaded.
    function automatic bit run_allowed();
        if (reg_iters == 0) return 1;
        for (int i = 0; i < eff_points(); i++)
            for (int k = 0; k < eff_dims(); k++)
                if (!pt_loaded[i][k]) return 0;
        for (int j = 0; j < eff_clusters(); j++)
            for (int k = 0; k < eff_dims(); k++)
                if (!cent_loaded[j][k]) return 0;
        return 1;
    endfunction

    // One assignment and update round over the shadow state.
    task automatic lloyd_round_model();
        int np;
        int nc;
        int nd;
        longint unsigned best;
        longint unsigned sq_dist;
        longint diff;
        longint sums[NCL][NDM];
        int counts[NCL];
        np = eff_points();
        nc = eff_clusters();
        nd = eff_dims();
        for (int i = 0; i < np; i++) begin
            best = 0;
            label_mem[i] = 4'd0;
            for (int j = 0; j < nc; j++) begin
                sq_dist = 0;
                for (int k = 0; k < nd; k++) begin
                    diff = longint'(pt_mem[i][k]) - longint'(cent_mem[j][k]);
                    sq_dist += longint'(diff * diff);
                end
                // Ties keep the lower cluster index.
                if (j == 0 || sq_dist < best) begin
                    best = sq_dist;
                    label_mem[i] = j[3:0];
                end
            end
        end
        for (int j = 0; j < NCL; j++) begin
            counts[j] = 0;
            for (int k = 0; k < NDM; k++) sums[j][k] = 0;
        end
        for (int i = 0; i < np; i++) begin
            counts[label_mem[i]]++;
            for (int k = 0; k < nd; k++) sums[label_mem[i]][k] += longint'(pt_mem[i][k]);
        end
        // Empty clusters keep their centroid; division truncates toward zero.
        for (int j = 0; j < nc; j++) begin
            if (counts[j] != 0) begin
                for (int k = 0; k < nd; k++)
                    cent_mem[j][k] = COORD_W'(sums[j][k] / longint'(counts[j]));
            end
        end
    endtask

    // Applies one accepted command word to the shadow state.
    task automatic engine_model(input logic [OP_W-1:0] op, input int row, input int dim,
                                input logic signed [COORD_W-1:0] coord,
                                output t_answer ans);
        ans.value  = '0;
        ans.status = 1'b0;
        case (op)
            OP_LOAD_POINT: begin
                if (row < eff_points() && dim < eff_dims()) begin
                    pt_mem[row][dim]    = coord;
                    pt_loaded[row][dim] = 1;
                end else begin
                    ans.status = 1'b1;
                end
            end
            OP_LOAD_CENT: begin
                if (row < eff_clusters() && dim < eff_dims()) begin
                    cent_mem[row][dim]    = coord;
                    cent_loaded[row][dim] = 1;
                end else begin
                    ans.status = 1'b1;
                end
            end
            OP_RUN: begin
                for (int it = 0; it < reg_iters; it++) lloyd_round_model();
            end
            OP_READ_LABEL: begin
                if (row < eff_points()) ans.value = {12'd0, label_mem[row]};
                else ans.status = 1'b1;
            end
            OP_READ_CENT: begin
                if (row < eff_clusters() && dim < eff_dims()) ans.value = cent_mem[row][dim];
                else ans.status = 1'b1;
            end
            default: ans.status = 1'b1;
        endcase
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: %s got %0d want %0d", $realtime, what, got, want);
        errors++;
    endtask

    // Result checker: the receiver never stalls, so every strobe is taken.
    t_answer head;
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (answer_q.size() == 0) begin
                report_mismatch("unexpected result, value", o_read_value, 0);
            end else begin
                head = answer_q.pop_front();
                if (o_read_value !== head.value)
                    report_mismatch("read_value", o_read_value, head.value);
                if (o_status !== head.status)
                    report_mismatch("status", o_status, head.status);
            end
        end
    end

    // Presents one command word and holds it until it is taken.
    task automatic send_word(input logic [OP_W-1:0] op, input int row, input int dim,
                             input logic signed [COORD_W-1:0] coord, input bit has_exp,
                             input logic signed [COORD_W-1:0] exp_value,
                             input logic exp_status);
        t_answer ans;
        int gap;
        start         <= 1'b1;
        i_op          <= op;
        i_row_index   <= ROW_W'(row);
        i_dim_index   <= DIMI_W'(dim);
        i_coord_value <= coord;
        do @(posedge i_clk); while (busy);
        engine_model(op, row, dim, coord, ans);
        if (has_exp) begin
            ans.value  = exp_value;
            ans.status = exp_status;
        end
        answer_q.push_back(ans);
        if ($urandom_range(0, 99) < gap_pct) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 3);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic random_word(input logic [OP_W-1:0] op, input int row, input int dim);
        send_word(op, row, dim, COORD_W'($urandom), 0, '0, 1'b0);
    endtask

    // Stops sending and waits until every answer has been seen.
    task automatic drain_answers();
        start <= 1'b0;
        while (answer_q.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFGI_W-1:0] idx, input int data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFGD_W'(data);
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_NUM_POINTS:   reg_points   = CFGD_W'(data);
            CFG_NUM_CLUSTERS: reg_clusters = 5'(data);
            CFG_NUM_DIMS:     reg_dims     = 5'(data);
            CFG_NUM_ITERS:    reg_iters    = 8'(data);
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // One setting of the sizes: optional full load, then a random mix of words.
    task automatic run_phase(input int np_w, input int nc_w, input int nd_w, input int it_w,
                             input int pct, input bit preload, input int n_words);
        int r;
        int row;
        int dim;
        drain_answers();
        write_reg(CFG_NUM_POINTS, np_w);
        write_reg(CFG_NUM_CLUSTERS, nc_w);
        write_reg(CFG_NUM_DIMS, nd_w);
        write_reg(CFG_NUM_ITERS, it_w);
        gap_pct = pct;
        if (preload) begin
            for (int i = 0; i < eff_points(); i++)
                for (int k = 0; k < eff_dims(); k++) random_word(OP_LOAD_POINT, i, k);
            for (int j = 0; j < eff_clusters(); j++)
                for (int k = 0; k < eff_dims(); k++) begin
                    // Seed centroids near stored points so clusters are not all empty.
                    if (j < eff_points() && $urandom_range(0, 1))
                        send_word(OP_LOAD_CENT, j, k, pt_mem[j][k], 0, '0, 1'b0);
                    else
                        random_word(OP_LOAD_CENT, j, k);
                end
        end
        for (int n = 0; n < n_words; n++) begin
            r = $urandom_range(0, 99);
            // Mostly in range; now and then anywhere in the field.
            row = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : -1;
            dim = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : -1;
            if (r < 30) begin
                if (row < 0) row = $urandom_range(0, eff_points() - 1);
                if (dim < 0) dim = $urandom_range(0, eff_dims() - 1);
                random_word(OP_LOAD_POINT, row, dim);
            end else if (r < 45 || r >= 97) begin
                if (row < 0) row = $urandom_range(0, eff_clusters() - 1);
                if (dim < 0) dim = $urandom_range(0, eff_dims() - 1);
                if (r >= 97) begin
                    random_word(OP_W'($urandom_range(5, 7)), row, dim);
                end else if (r < 45) begin
                    random_word(OP_LOAD_CENT, row, dim);
                end
            end else if (r < 70) begin
                if (row < 0) row = $urandom_range(0, eff_points() - 1);
                if (dim < 0) dim = $urandom_range(0, 15);
                random_word(OP_READ_LABEL, row, dim);
            end else if (r < 95) begin
                if (row < 0) row = $urandom_range(0, eff_clusters() - 1);
                if (dim < 0) dim = $urandom_range(0, eff_dims() - 1);
                // Never read a centroid entry that was not loaded.
                if (row < eff_clusters() && dim < eff_dims() && !cent_loaded[row][dim])
                    random_word(OP_LOAD_CENT, row, dim);
                else
                    random_word(OP_READ_CENT, row, dim);
            end else begin
                if (run_allowed()) random_word(OP_RUN, 0, 0);
                else random_word(OP_READ_LABEL, 0, 0);
            end
        end
        if (run_allowed()) begin
            random_word(OP_RUN, $urandom_range(0, 1023), $urandom_range(0, 15));
            // Wait for the run's answer, then read back some labels and centroids.
            drain_answers();
            for (int i = 0; i < eff_points() && i < 32; i++) random_word(OP_READ_LABEL, i, 0);
            for (int j = 0; j < eff_clusters(); j++)
                if (cent_loaded[j][0]) random_word(OP_READ_CENT, j, 0);
        end
    endtask

    initial begin
        errors        = 0;
        gap_pct       = 0;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_op          = OP_LOAD_POINT;
        i_row_index   = '0;
        i_dim_index   = '0;
        i_coord_value = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_NUM_POINTS;
        i_cfg_data    = '0;
        reg_points    = 11'd1;
        reg_clusters  = 5'd1;
        reg_dims      = 5'd1;
        reg_iters     = 8'd0;
        for (int i = 0; i < NPT; i++) begin
            label_mem[i] = 4'd0;
            for (int k = 0; k < NDM; k++) begin
                pt_mem[i][k]    = '0;
                pt_loaded[i][k] = 0;
            end
        end
        for (int j = 0; j < NCL; j++)
            for (int k = 0; k < NDM; k++) begin
                cent_mem[j][k]    = '0;
                cent_loaded[j][k] = 0;
            end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset sizes: one point, one cluster, one dimension.
        foreach (directed[n])
            send_word(directed[n].op, directed[n].row, directed[n].dim, directed[n].coord,
                      directed[n].has_exp, directed[n].exp_value, directed[n].exp_status);

        // Random phases: sizes, rounds, sender idling, preload, word count.
        run_phase(8, 3, 2, 2, 0, 1, 100);
        run_phase(16, 4, 4, 1, 61, 1, 100);
        // Zero sizes saturate up to one.
        run_phase(0, 0, 0, 3, 0, 1, 50);
        // Oversized registers saturate to the maxima; no rounds, so no full load.
        run_phase(2047, 31, 31, 0, 37, 0, 60);
        run_phase(20, 16, 2, 1, 61, 1, 100);
        // Most rounds allowed, on a tiny data set.
        run_phase(2, 2, 1, 255, 0, 1, 30);
        run_phase(12, 5, 3, 2, 37, 1, 100);
        // Largest point count with real rounds.
        run_phase(1024, 1, 1, 1, 0, 1, 20);

        drain_answers();
        repeat (20) @(posedge i_clk);
        if (answer_q.size() != 0) begin
            report_mismatch("answers never arrived", answer_q.size(), 0);
        end
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog well above the slowest legal run.
    initial begin
        #100_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/kml_pkg.sv
rtl/kml_div.sv
rtl/kml_dp.sv
rtl/kml_ctrl.sv
rtl/kmeans_lloyd_iterations_top.sv
sim/kmeans_lloyd_iterations_top_tb.sv
